>>> src/qrs_pkg.sv
// Package for the quadratic root solver: widths, status codes and the beat
// types that travel down the square root and divider cell chains. No dependencies.
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int CoefWidth = 16;
  localparam int FracBits  = 16;
  localparam int RootWidth = 40;

  // Discriminant is at most b^2 + 4|ac| < 2^33
  localparam int DiscWidth = 2 * CoefWidth + 1;
  // Radicand disc << 2*FracBits, padded to an even bit count
  localparam int RadWidth  = DiscWidth + 2 * FracBits + 1;
  localparam int SqrtBits  = RadWidth / 2;
  localparam int SremWidth = SqrtBits + 3;
  // Numerator -b*2^f +/- root, magnitude only
  localparam int NumWidth  = SqrtBits + 1;
  localparam int DenWidth  = CoefWidth + 1;
  localparam int DremWidth = DenWidth + 1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_AZERO = 2'd1;
  localparam logic [1:0] ST_CPLX  = 2'd2;

  typedef struct packed {
    logic signed [CoefWidth-1:0] a;
    logic signed [CoefWidth-1:0] b;
    logic [1:0]                  st;
    logic                        dbl;
    logic [RadWidth-1:0]         n;
    logic [SremWidth-1:0]        rem;
    logic [SqrtBits-1:0]         root;
  } sq_t;

  typedef struct packed {
    logic [1:0]           st;
    logic                 dbl;
    logic                 neg_p;
    logic                 neg_m;
    logic [NumWidth-1:0]  num_p;
    logic [NumWidth-1:0]  num_m;
    logic [DenWidth-1:0]  den;
    logic [DremWidth-1:0] rem_p;
    logic [DremWidth-1:0] rem_m;
    logic [NumWidth-1:0]  q_p;
    logic [NumWidth-1:0]  q_m;
  } dv_t;

endpackage

>>> src/qrs_sqrt_cell.sv
// One digit cell of the square root chain: retires one root bit per beat.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  sq_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output sq_t  dn_data
);

  logic valid_r;
  sq_t  data_r;
  sq_t  data_nxt;
  logic [SremWidth-1:0] rem_sh;
  logic [SremWidth-1:0] trial;
  logic ge;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    rem_sh   = {up_data.rem[SremWidth-3:0], up_data.n[RadWidth-1 -: 2]};
    trial    = {up_data.root, 2'b01};
    ge       = rem_sh >= trial;
    data_nxt = up_data;
    data_nxt.n    = {up_data.n[RadWidth-3:0], 2'b00};
    data_nxt.rem  = ge ? rem_sh - trial : rem_sh;
    data_nxt.root = {up_data.root[SqrtBits-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> src/qrs_div_cell.sv
// One cell of the divider chain: one quotient bit for each of the two roots.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  dv_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output dv_t  dn_data
);

  logic valid_r;
  dv_t  data_r;
  dv_t  data_nxt;
  logic [DremWidth-1:0] rp;
  logic [DremWidth-1:0] rm;
  logic [DremWidth-1:0] dx;
  logic gp;
  logic gm;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    dx = {1'b0, up_data.den};
    rp = {up_data.rem_p[DremWidth-2:0], up_data.num_p[NumWidth-1]};
    rm = {up_data.rem_m[DremWidth-2:0], up_data.num_m[NumWidth-1]};
    gp = rp >= dx;
    gm = rm >= dx;
    data_nxt = up_data;
    data_nxt.num_p = {up_data.num_p[NumWidth-2:0], 1'b0};
    data_nxt.num_m = {up_data.num_m[NumWidth-2:0], 1'b0};
    data_nxt.rem_p = gp ? rp - dx : rp;
    data_nxt.rem_m = gm ? rm - dx : rm;
    data_nxt.q_p   = {up_data.q_p[NumWidth-2:0], gp};
    data_nxt.q_m   = {up_data.q_m[NumWidth-2:0], gm};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> src/quadratic_root_solver.sv
// Pipelined real root solver for a*x^2 + b*x + c with signed 16-bit coefficients.
// One beat in and one beat out per cycle while the receiver keeps out_ready high; the stages are
// multiply, discriminant, 33 square root cells, numerator prep, 34 divider cells and the
// output register, one cell per root or quotient bit. Each stage only stalls when
// the stage after it is full and blocked, so bubbles are squeezed out under backpressure.
// Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell.
`timescale 1ns / 1ps
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [CoefWidth-1:0] in_coef_a,
  input  logic signed [CoefWidth-1:0] in_coef_b,
  input  logic signed [CoefWidth-1:0] in_coef_c,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [RootWidth-1:0] out_root_plus,
  output logic signed [RootWidth-1:0] out_root_minus,
  output logic [1:0]                  out_status,
  output logic                        out_double_root
);

  // stage 1: products
  logic                        m_valid_r;
  logic                        m_ready;
  logic signed [CoefWidth-1:0] m_a_r;
  logic signed [CoefWidth-1:0] m_b_r;
  logic                        m_sub_r;
  logic [2*CoefWidth-1:0]      m_bsq_r;
  logic [2*CoefWidth-1:0]      m_ac_r;
  logic [CoefWidth-1:0]        mag_a;
  logic [CoefWidth-1:0]        mag_b;
  logic [CoefWidth-1:0]        mag_c;

  assign mag_a = in_coef_a[CoefWidth-1] ? -in_coef_a : in_coef_a;
  assign mag_b = in_coef_b[CoefWidth-1] ? -in_coef_b : in_coef_b;
  assign mag_c = in_coef_c[CoefWidth-1] ? -in_coef_c : in_coef_c;
  assign in_ready = !m_valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (in_ready) begin
      m_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      m_a_r   <= in_coef_a;
      m_b_r   <= in_coef_b;
      m_sub_r <= (in_coef_c != '0) && (in_coef_a[CoefWidth-1] == in_coef_c[CoefWidth-1]);
      m_bsq_r <= mag_b * mag_b;
      m_ac_r  <= mag_a * mag_c;
    end
  end

  // stage 2: discriminant and status
  logic                 d_valid_r;
  logic                 d_ready;
  sq_t                  d_data_r;
  sq_t                  d_nxt;
  logic [DiscWidth-1:0] fac;
  logic [DiscWidth-1:0] bsq;
  logic [DiscWidth-1:0] disc;

  assign m_ready = !d_valid_r || d_ready;

  always_comb begin
    bsq  = {1'b0, m_bsq_r};
    fac  = {m_ac_r[DiscWidth-3:0], 2'b00};
    disc = m_sub_r ? bsq - fac : bsq + fac;
    d_nxt.a    = m_a_r;
    d_nxt.b    = m_b_r;
    d_nxt.rem  = '0;
    d_nxt.root = '0;
    d_nxt.n    = {1'b0, disc, {(2*FracBits){1'b0}}};
    d_nxt.dbl  = 1'b0;
    if (m_a_r == '0) begin
      d_nxt.st = ST_AZERO;
    end else if (m_sub_r && (bsq < fac)) begin
      d_nxt.st = ST_CPLX;
    end else begin
      d_nxt.st  = ST_OK;
      d_nxt.dbl = (disc == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (m_ready) begin
      d_valid_r <= m_valid_r;
    end
    if (m_ready && m_valid_r) begin
      d_data_r <= d_nxt;
    end
  end

  // square root chain
  logic sq_v   [SqrtBits+1];
  logic sq_rdy [SqrtBits+1];
  sq_t  sq_d   [SqrtBits+1];

  assign sq_v[0] = d_valid_r;
  assign sq_d[0] = d_data_r;
  assign d_ready = sq_rdy[0];

  for (genvar i = 0; i < SqrtBits; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_v[i]),
      .up_ready (sq_rdy[i]),
      .up_data  (sq_d[i]),
      .dn_valid (sq_v[i+1]),
      .dn_ready (sq_rdy[i+1]),
      .dn_data  (sq_d[i+1])
    );
  end

  // stage 3: numerators and divisor magnitudes
  logic                       p_valid_r;
  logic                       p_ready;
  dv_t                        p_data_r;
  dv_t                        p_nxt;
  logic signed [NumWidth:0]   base;
  logic signed [NumWidth:0]   np;
  logic signed [NumWidth:0]   nm;
  logic signed [NumWidth:0]   rootx;
  logic [CoefWidth-1:0]       mag_pa;
  logic                       sa;
  sq_t                        sq_last;

  assign sq_last         = sq_d[SqrtBits];
  assign sq_rdy[SqrtBits] = !p_valid_r || p_ready;

  always_comb begin
    sa     = sq_last.a[CoefWidth-1];
    mag_pa = sa ? -sq_last.a : sq_last.a;
    base   = -((NumWidth+1)'(sq_last.b) <<< FracBits);
    rootx  = (NumWidth+1)'({1'b0, sq_last.root});
    np     = base + rootx;
    nm     = base - rootx;
    p_nxt.st    = sq_last.st;
    p_nxt.dbl   = sq_last.dbl;
    p_nxt.neg_p = np[NumWidth] ^ sa;
    p_nxt.neg_m = nm[NumWidth] ^ sa;
    p_nxt.num_p = NumWidth'(np[NumWidth] ? -np : np);
    p_nxt.num_m = NumWidth'(nm[NumWidth] ? -nm : nm);
    p_nxt.den   = {mag_pa, 1'b0};
    p_nxt.rem_p = '0;
    p_nxt.rem_m = '0;
    p_nxt.q_p   = '0;
    p_nxt.q_m   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (sq_rdy[SqrtBits]) begin
      p_valid_r <= sq_v[SqrtBits];
    end
    if (sq_rdy[SqrtBits] && sq_v[SqrtBits]) begin
      p_data_r <= p_nxt;
    end
  end

  // divider chain
  logic dv_v   [NumWidth+1];
  logic dv_rdy [NumWidth+1];
  dv_t  dv_d   [NumWidth+1];

  assign dv_v[0] = p_valid_r;
  assign dv_d[0] = p_data_r;
  assign p_ready = dv_rdy[0];

  for (genvar j = 0; j < NumWidth; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_v[j]),
      .up_ready (dv_rdy[j]),
      .up_data  (dv_d[j]),
      .dn_valid (dv_v[j+1]),
      .dn_ready (dv_rdy[j+1]),
      .dn_data  (dv_d[j+1])
    );
  end

  // output register: sign, error zeroing
  logic                        o_valid_r;
  logic signed [RootWidth-1:0] o_plus_r;
  logic signed [RootWidth-1:0] o_minus_r;
  logic [1:0]                  o_st_r;
  logic                        o_dbl_r;
  logic signed [RootWidth-1:0] qp_x;
  logic signed [RootWidth-1:0] qm_x;
  logic                        ok;
  dv_t                         dv_last;

  assign dv_last          = dv_d[NumWidth];
  assign dv_rdy[NumWidth] = !o_valid_r || out_ready;
  assign ok               = dv_last.st == ST_OK;
  assign qp_x = RootWidth'(dv_last.q_p);
  assign qm_x = RootWidth'(dv_last.q_m);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (dv_rdy[NumWidth]) begin
      o_valid_r <= dv_v[NumWidth];
    end
    if (dv_rdy[NumWidth] && dv_v[NumWidth]) begin
      o_plus_r  <= !ok ? '0 : (dv_last.neg_p ? -qp_x : qp_x);
      o_minus_r <= !ok ? '0 : (dv_last.neg_m ? -qm_x : qm_x);
      o_st_r    <= dv_last.st;
      o_dbl_r   <= dv_last.dbl;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_root_plus   = o_plus_r;
  assign out_root_minus  = o_minus_r;
  assign out_status      = o_st_r;
  assign out_double_root = o_dbl_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_root_plus == '0) && (out_root_minus == '0))
    else $error("error status with nonzero root");
  a_dbl_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_double_root |-> (out_root_plus == out_root_minus))
    else $error("double root with differing roots");
  a_dbl_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_double_root |-> (out_status == ST_OK))
    else $error("double root flagged on error");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_root_plus) && $stable(out_status))
    else $error("output beat changed while stalled");
`endif

endmodule

>>> test/quadratic_root_solver_tb.sv
// Testbench for quadratic_root_solver: directed and random coefficient sets are
// checked against a built-in root predictor with random stalls on both sides.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
`timescale 1ns / 1ps
module quadratic_root_solver_tb;
  import qrs_pkg::*;

  typedef struct {
    logic signed [RootWidth-1:0] rp;
    logic signed [RootWidth-1:0] rm;
    logic [1:0]                  st;
    logic                        dbl;
  } roots_t;

  class root_scoreboard;
    roots_t pending_roots[$];
    int     errors = 0;
    int     n_in = 0;
    int     n_out = 0;
    int     n_status[3] = '{0, 0, 0};
    int     n_double = 0;

    // isqrt of disc * 2^(2*FracBits), truncated
    function automatic logic [39:0] isqrt_scaled(longint disc);
      logic [79:0] n;
      logic [39:0] r;
      logic [39:0] cand;
      n = 80'(disc) << (2 * FracBits);
      r = '0;
      for (int i = 39; i >= 0; i--) begin
        cand = r | (40'd1 << i);
        if ((80'(cand) * 80'(cand)) <= n) r = cand;
      end
      return r;
    endfunction

    function automatic logic signed [RootWidth-1:0] clamp(longint v);
      longint hi;
      hi = (longint'(1) <<< (RootWidth - 1)) - 1;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return v[RootWidth-1:0];
    endfunction

    function void note_input(logic signed [CoefWidth-1:0] a, logic signed [CoefWidth-1:0] b,
                             logic signed [CoefWidth-1:0] c);
      roots_t e;
      longint disc, base, den;
      longint root;
      e.rp = '0; e.rm = '0; e.st = ST_OK; e.dbl = 1'b0;
      n_in++;
      if (a == 0) begin
        e.st = ST_AZERO;
      end else begin
        disc = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
        if (disc < 0) begin
          e.st = ST_CPLX;
        end else begin
          e.dbl = (disc == 0);
          root = longint'(isqrt_scaled(disc));
          base = -longint'(b) * (longint'(1) <<< FracBits);
          den = 2 * longint'(a);
          e.rp = clamp((base + root) / den);
          e.rm = clamp((base - root) / den);
        end
      end
      pending_roots.push_back(e);
    endfunction

    function void report(string what, longint got, longint want);
      errors++;
      $display("mismatch on result %0d: %s got %0d expected %0d", n_out, what, got, want);
    endfunction

    function void check_result(logic signed [RootWidth-1:0] rp, logic signed [RootWidth-1:0] rm,
                               logic [1:0] st, logic dbl);
      roots_t e;
      if (pending_roots.size() == 0) begin
        report("unexpected beat", 0, 0);
        return;
      end
      e = pending_roots.pop_front();
      if (rp !== e.rp) report("root_plus", rp, e.rp);
      if (rm !== e.rm) report("root_minus", rm, e.rm);
      if (st !== e.st) report("status", st, e.st);
      if (dbl !== e.dbl) report("double_root", dbl, e.dbl);
      if (e.st <= ST_CPLX) n_status[e.st]++;
      if (e.dbl) n_double++;
      n_out++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CoefWidth-1:0] in_coef_a = '0;
  logic signed [CoefWidth-1:0] in_coef_b = '0;
  logic signed [CoefWidth-1:0] in_coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RootWidth-1:0] out_root_plus;
  logic signed [RootWidth-1:0] out_root_minus;
  logic [1:0] out_status;
  logic out_double_root;

  root_scoreboard sb = new();

  quadratic_root_solver dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_root_plus, out_root_minus, out_status, out_double_root);

  task automatic send_coefs(int a, int b, int c);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_coef_a <= a[CoefWidth-1:0];
    in_coef_b <= b[CoefWidth-1:0];
    in_coef_c <= c[CoefWidth-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(a[CoefWidth-1:0], b[CoefWidth-1:0], c[CoefWidth-1:0]);
  endtask

  // Receiver: random stalls, one long hold-off so the pipe fills and blocks input
  initial begin
    int gap;
    int held;
    held = 0;
    @(posedge rst_n);
    forever begin
      if (held == 0 && sb.n_in > 600) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int a, b, c, k, m;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero leading coefficient, complex and double roots
    send_coefs(1, 0, 0);
    send_coefs(1, 2, 1);
    send_coefs(-1, 2, -1);
    send_coefs(1, 0, 1);
    send_coefs(0, 5, 7);
    send_coefs(0, 0, 0);
    send_coefs(0, -32768, 32767);
    send_coefs(32767, -32768, -32768);
    send_coefs(-32768, -32768, 32767);
    send_coefs(-32768, 32767, -32768);
    send_coefs(-32768, -32768, -32768);
    send_coefs(32767, 32767, 32767);
    send_coefs(1, -32768, -32768);
    send_coefs(1, -32768, 32767);
    send_coefs(-1, 32767, 32767);
    send_coefs(1, 32767, -32768);
    send_coefs(2, -3, 1);
    send_coefs(3, 1, -7);
    send_coefs(-5, 0, 0);
    send_coefs(1, -1, 0);
    send_coefs(256, -512, 256);

    for (int i = 0; i < 1600; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          send_coefs(0, $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
        end
        1, 2: begin
          // exact double root: a*(x+m)^2
          k = $urandom_range(1, 90);
          m = $urandom_range(0, 18) - 9;
          if ($urandom_range(0, 1)) k = -k;
          send_coefs(k, 2 * k * m, k * m * m);
        end
        3, 4: begin
          a = $urandom_range(0, 40) - 20;
          b = $urandom_range(0, 80) - 40;
          c = $urandom_range(0, 40) - 20;
          send_coefs(a, b, c);
        end
        default: begin
          send_coefs($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                     $urandom_range(0, 65535) - 32768);
        end
      endcase
    end
    in_valid <= 1'b0;

    while (sb.pending_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d coefficient sets checked: %0d real, %0d zero-a, %0d complex, %0d double roots",
             sb.n_out, sb.n_status[ST_OK], sb.n_status[ST_AZERO], sb.n_status[ST_CPLX],
             sb.n_double);
    if (sb.errors == 0 && sb.n_in == sb.n_out) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", sb.pending_roots.size());
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
src/qrs_pkg.sv
src/qrs_sqrt_cell.sv
src/qrs_div_cell.sv
src/quadratic_root_solver.sv
test/quadratic_root_solver_tb.sv
